// File: rtl/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// MIT command frame packer package
// Shared constants, payload types and arithmetic helpers of the packer.
// ----------------------------------------------------------------------------
package mcfp_pkg;

  localparam int unsigned NumCh    = 5;
  localparam int unsigned LimW     = 31;
  localparam int unsigned ValW     = 32;
  localparam int unsigned IdW      = 11;
  localparam int unsigned PosBits  = 16;
  localparam int unsigned ChBits   = 12;
  localparam int unsigned QuoW     = PosBits;
  localparam int unsigned NumW     = ValW + QuoW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivStg   = QuoW;
  localparam int unsigned NumStg   = DivStg + 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCanId     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPosLimit  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVelLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStfLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDmpLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTorLimit  = 3'd5;

  // Channel order inside the pipeline.
  localparam int unsigned ChPos = 0;
  localparam int unsigned ChVel = 1;
  localparam int unsigned ChStf = 2;
  localparam int unsigned ChDmp = 3;
  localparam int unsigned ChTor = 4;

  typedef struct packed {
    logic signed [ValW-1:0] position;
    logic signed [ValW-1:0] velocity;
    logic signed [ValW-1:0] stiffness_gain;
    logic signed [ValW-1:0] damping_gain;
    logic signed [ValW-1:0] torque_ff;
  } cmd_t;

  // One channel in flight: partial remainder, numerator low bits that turn
  // into quotient bits, and the divisor.
  typedef struct packed {
    logic [ValW-1:0] rem;
    logic [QuoW-1:0] wrk;
    logic [ValW-1:0] den;
  } ch_t;

  typedef ch_t [NumCh-1:0] stg_t;

  // Clamp to -lim..+lim and return the offset from -lim with span 2*lim.
  function automatic ch_t clamp_sym(logic signed [ValW-1:0] v, logic [LimW-1:0] lim);
    logic signed [ValW:0] vx;
    logic signed [ValW:0] lx;
    logic [ValW:0]        sum;
    ch_t                  c;
    vx    = {v[ValW-1], v};
    lx    = {2'b00, lim};
    sum   = vx + lx;
    c.wrk = '0;
    c.den = (lim == '0) ? ValW'(1) : {lim, 1'b0};
    if (vx < -lx) begin
      c.rem = '0;
    end else if (vx > lx) begin
      c.rem = {lim, 1'b0};
    end else begin
      c.rem = sum[ValW-1:0];
    end
    return c;
  endfunction

  // Clamp to 0..lim.
  function automatic ch_t clamp_pos(logic signed [ValW-1:0] v, logic [LimW-1:0] lim);
    ch_t c;
    c.wrk = '0;
    c.den = (lim == '0) ? ValW'(1) : {1'b0, lim};
    if (v[ValW-1]) begin
      c.rem = '0;
    end else if (v[ValW-2:0] > lim) begin
      c.rem = {1'b0, lim};
    end else begin
      c.rem = v;
    end
    return c;
  endfunction

  // off * (2^bits - 1), split into the high remainder and low work bits.
  function automatic ch_t scale(ch_t c, logic wide);
    logic [NumW-1:0] off;
    logic [NumW-1:0] num;
    ch_t             r;
    off   = {{QuoW{1'b0}}, c.rem};
    num   = wide ? ((off << PosBits) - off) : ((off << ChBits) - off);
    r.rem = num[NumW-1:QuoW];
    r.wrk = num[QuoW-1:0];
    r.den = c.den;
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic ch_t div_step(ch_t c);
    logic [ValW:0] t;
    logic [ValW:0] d;
    logic          ge;
    ch_t           r;
    t     = {c.rem, c.wrk[QuoW-1]};
    d     = {1'b0, c.den};
    ge    = (t >= d);
    t     = ge ? (t - d) : t;
    r.rem = t[ValW-1:0];
    r.wrk = {c.wrk[QuoW-2:0], ge};
    r.den = c.den;
    return r;
  endfunction

endpackage

// File: rtl/mcfp_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one five-value motor command.
// ----------------------------------------------------------------------------
interface mcfp_cmd_if import mcfp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] position;
  logic signed [ValW-1:0] velocity;
  logic signed [ValW-1:0] stiffness_gain;
  logic signed [ValW-1:0] damping_gain;
  logic signed [ValW-1:0] torque_ff;

  modport source (output valid, position, velocity, stiffness_gain, damping_gain,
                  torque_ff, input ready);
  modport sink   (input valid, position, velocity, stiffness_gain, damping_gain,
                  torque_ff, output ready);
endinterface

// File: rtl/mcfp_frm_if.sv
// ----------------------------------------------------------------------------
// Frame channel
// Valid/ready channel that carries one CAN identifier and 8-byte payload.
// ----------------------------------------------------------------------------
interface mcfp_frm_if import mcfp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdW-1:0]  frame_id;
  logic [63:0]     payload;

  modport source (output valid, frame_id, payload, input ready);
  modport sink   (input valid, frame_id, payload, output ready);
endinterface

// File: rtl/mit_command_frame_packer_unit.sv
// ----------------------------------------------------------------------------
// MIT command frame packer
// Clamps five Q16.16 command values, quantizes them and packs a CAN frame.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the output is not stalled
// and gives one frame per request, in order. The quantizer has one clamp
// stage, one scaling stage and sixteen restoring division stages, each of
// which produces one quotient bit for all five channels in parallel. Every
// stage has its own valid bit and its own ready term, so a stalled output
// only holds the stages that are full and bubbles ahead of it still close
// up. Configuration must be written while no request is in flight; limits
// and the frame identifier are read live by the pipeline.
module mit_command_frame_packer_unit import mcfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LimW-1:0]    cfg_data_i,
  mcfp_cmd_if.sink           cmd,
  mcfp_frm_if.source         frm
);

  // Configuration registers.
  logic [IdW-1:0]  can_id_q;
  logic [LimW-1:0] pos_lim_q, vel_lim_q, stf_lim_q, dmp_lim_q, tor_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      can_id_q  <= IdW'(1);
      pos_lim_q <= LimW'(819200);
      vel_lim_q <= LimW'(2949120);
      stf_lim_q <= LimW'(32768000);
      dmp_lim_q <= LimW'(327680);
      tor_lim_q <= LimW'(1179648);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCanId:    can_id_q  <= cfg_data_i[IdW-1:0];
        RegPosLimit: pos_lim_q <= cfg_data_i;
        RegVelLimit: vel_lim_q <= cfg_data_i;
        RegStfLimit: stf_lim_q <= cfg_data_i;
        RegDmpLimit: dmp_lim_q <= cfg_data_i;
        RegTorLimit: tor_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 0 holds clamped offsets, stage 1 the scaled numerators, and the
  // remaining stages one more quotient bit each.
  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   rdy;
  stg_t              stg_q [NumStg];
  stg_t              clamp_d, scale_d;

  // The ready terms are built from the output backwards.
  always_comb begin
    rdy[NumStg] = frm.ready;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign cmd.ready = rdy[0];

  always_comb begin
    clamp_d[ChPos] = clamp_sym(cmd.position, pos_lim_q);
    clamp_d[ChVel] = clamp_sym(cmd.velocity, vel_lim_q);
    clamp_d[ChStf] = clamp_pos(cmd.stiffness_gain, stf_lim_q);
    clamp_d[ChDmp] = clamp_pos(cmd.damping_gain, dmp_lim_q);
    clamp_d[ChTor] = clamp_sym(cmd.torque_ff, tor_lim_q);
    for (int c = 0; c < NumCh; c++) begin
      scale_d[c] = scale(stg_q[0][c], c == ChPos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= cmd.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && cmd.valid) begin
      stg_q[0] <= clamp_d;
    end
    if (rdy[1] && vld_q[0]) begin
      stg_q[1] <= scale_d;
    end
    for (int k = 2; k < NumStg; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        for (int c = 0; c < NumCh; c++) begin
          stg_q[k][c] <= div_step(stg_q[k-1][c]);
        end
      end
    end
  end

  assign frm.valid    = vld_q[NumStg-1];
  assign frm.frame_id = can_id_q;
  assign frm.payload  = {stg_q[NumStg-1][ChPos].wrk,
                         stg_q[NumStg-1][ChVel].wrk[ChBits-1:0],
                         stg_q[NumStg-1][ChStf].wrk[ChBits-1:0],
                         stg_q[NumStg-1][ChDmp].wrk[ChBits-1:0],
                         stg_q[NumStg-1][ChTor].wrk[ChBits-1:0]};

  // The input only stalls when every stage is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.ready |-> &vld_q)
    else $error("input stalled while the pipeline has a free stage");

  // The position remainder of a valid last stage stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStg-1] |-> stg_q[NumStg-1][ChPos].rem < stg_q[NumStg-1][ChPos].den)
    else $error("position remainder not below divisor");

  // The scaling stage, holding a request while the next is blocked, keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !rdy[2] |=> vld_q[1])
    else $error("request lost in scaling stage");

  // A request taken at the input shows up in the clamp stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.valid && cmd.ready |=> vld_q[0])
    else $error("accepted request missing from clamp stage");

endmodule

// File: sim/mcfp_frame_checker.sv
// ----------------------------------------------------------------------------
// Command frame packer checker
// Watches the command and frame channels and the configuration port, predicts
// each frame from the accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module mcfp_frame_checker import mcfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LimW-1:0]    cfg_data_i,
  mcfp_cmd_if                cmd,
  mcfp_frm_if                frm,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IdW-1:0] frame_id;
    logic [63:0]    payload;
  } frame_t;

  logic [IdW-1:0]  id_q;
  logic [LimW-1:0] lim_q [NumCh];
  frame_t          frames_due [$];
  int              mism_cnt;

  // Clamp and floor-map one value; sym selects the -lim..+lim range.
  function automatic logic [15:0] quantize_value(logic signed [ValW-1:0] v,
                                                 logic [LimW-1:0] lim, bit sym,
                                                 int bits);
    longint lo, hi, x;
    longint unsigned span, full;
    lo = sym ? -longint'(lim) : 64'sd0;
    hi = longint'(lim);
    span = hi - lo;
    if (span == 0) return '0;
    full = (64'd1 << bits) - 1;
    x = v;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return 16'(((x - lo) * full) / span);
  endfunction

  function automatic frame_t pack_frame(cmd_t c);
    frame_t      f;
    logic [15:0] pos, vel, kp, kd, tor;
    pos = quantize_value(c.position, lim_q[ChPos], 1'b1, PosBits);
    vel = quantize_value(c.velocity, lim_q[ChVel], 1'b1, ChBits);
    kp  = quantize_value(c.stiffness_gain, lim_q[ChStf], 1'b0, ChBits);
    kd  = quantize_value(c.damping_gain, lim_q[ChDmp], 1'b0, ChBits);
    tor = quantize_value(c.torque_ff, lim_q[ChTor], 1'b1, ChBits);
    f.frame_id = id_q;
    f.payload = {pos, vel[11:0], kp[11:0], kd[11:0], tor[11:0]};
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t   c;
    frame_t f;
    if (!rst_ni) begin
      id_q <= IdW'(1);
      lim_q[ChPos] <= LimW'(819200);
      lim_q[ChVel] <= LimW'(2949120);
      lim_q[ChStf] <= LimW'(32768000);
      lim_q[ChDmp] <= LimW'(327680);
      lim_q[ChTor] <= LimW'(1179648);
      frames_due.delete();
      fail_cnt_o <= 0;
      mism_cnt = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        c.position = cmd.position;
        c.velocity = cmd.velocity;
        c.stiffness_gain = cmd.stiffness_gain;
        c.damping_gain = cmd.damping_gain;
        c.torque_ff = cmd.torque_ff;
        frames_due.push_back(pack_frame(c));
      end
      if (frm.valid && frm.ready) begin
        if (frames_due.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("Unexpected frame id=%h payload=%h", frm.frame_id, frm.payload);
        end else begin
          f = frames_due.pop_front();
          if (f.frame_id !== frm.frame_id || f.payload !== frm.payload) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("Frame mismatch: expected id=%h payload=%h, got id=%h payload=%h",
                       f.frame_id, f.payload, frm.frame_id, frm.payload);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCanId:    id_q <= cfg_data_i[IdW-1:0];
          RegPosLimit: lim_q[ChPos] <= cfg_data_i;
          RegVelLimit: lim_q[ChVel] <= cfg_data_i;
          RegStfLimit: lim_q[ChStf] <= cfg_data_i;
          RegDmpLimit: lim_q[ChDmp] <= cfg_data_i;
          RegTorLimit: lim_q[ChTor] <= cfg_data_i;
          default: ;
        endcase
      end
      fail_cnt_o <= mism_cnt;
    end
  end

  assign pending_o = frames_due.size();

endmodule

// File: sim/mit_command_frame_packer_unit_tb.sv
// ----------------------------------------------------------------------------
// Command frame packer testbench
// Drives directed and random motor commands under several limit settings,
// with random gaps on both channels, and lets the checker judge the frames.
// ----------------------------------------------------------------------------
module mit_command_frame_packer_unit_tb import mcfp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 4000;
  localparam int DrainWait  = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [LimW-1:0]    cfg_data = '0;
  int                 fail_cnt;
  int                 pending;
  int                 idle_cnt = 0;
  int                 sent = 0;
  bit                 quiet = 1'b0;
  logic [LimW-1:0]    lim_sh [NumCh];

  mcfp_cmd_if cmd_ch ();
  mcfp_frm_if frm_ch ();

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.position = '0;
    cmd_ch.velocity = '0;
    cmd_ch.stiffness_gain = '0;
    cmd_ch.damping_gain = '0;
    cmd_ch.torque_ff = '0;
    frm_ch.ready = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  mit_command_frame_packer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd        (cmd_ch),
    .frm        (frm_ch)
  );

  mcfp_frame_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd        (cmd_ch),
    .frm        (frm_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // The receiver stalls now and then, except during the quiet stretch.
  always @(posedge clk_i) begin
    frm_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (frm_ch.valid && frm_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WatchLimit) begin
        $display("Watchdog expired with %0d frames outstanding", pending);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Block until every predicted frame is out, then let the pipeline settle so
  // that a configuration write cannot hit a request in flight.
  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One register write; the enable drops again afterwards so that
  // back-to-back writes never assign it twice in one time step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx >= RegPosLimit && idx <= RegTorLimit) lim_sh[idx - 1] = data;
  endtask

  task automatic set_limits(logic [LimW-1:0] id, logic [LimW-1:0] p, logic [LimW-1:0] v,
                            logic [LimW-1:0] k, logic [LimW-1:0] d, logic [LimW-1:0] t);
    wait_drained();
    write_reg(RegCanId, id);
    write_reg(RegPosLimit, p);
    write_reg(RegVelLimit, v);
    write_reg(RegStfLimit, k);
    write_reg(RegDmpLimit, d);
    write_reg(RegTorLimit, t);
  endtask

  // Sends one request. The sender may idle first; valid only drops when a
  // gap is actually taken, so it never toggles within one time step.
  task automatic send_cmd(cmd_t c);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.position <= c.position;
    cmd_ch.velocity <= c.velocity;
    cmd_ch.stiffness_gain <= c.stiffness_gain;
    cmd_ch.damping_gain <= c.damping_gain;
    cmd_ch.torque_ff <= c.torque_ff;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic stop_cmd();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks a value near or inside the range of a channel: bounds, just past
  // the bounds, anything at all, or a point inside the range.
  function automatic logic signed [31:0] pick_value(logic [LimW-1:0] lim, bit sym);
    longint lo, hi, x;
    longint unsigned span;
    lo = sym ? -longint'(lim) : 64'sd0;
    hi = longint'(lim);
    span = hi - lo + 1;
    case ($urandom_range(0, 9))
      0: x = $signed($urandom);
      1: x = lo;
      2: x = hi;
      3: x = lo - 1;
      4: x = hi + 1;
      default: x = lo + longint'({$urandom, $urandom} % span);
    endcase
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return 32'(x);
  endfunction

  function automatic cmd_t pick_cmd();
    cmd_t c;
    c.position = pick_value(lim_sh[ChPos], 1'b1);
    c.velocity = pick_value(lim_sh[ChVel], 1'b1);
    c.stiffness_gain = pick_value(lim_sh[ChStf], 1'b0);
    c.damping_gain = pick_value(lim_sh[ChDmp], 1'b0);
    c.torque_ff = pick_value(lim_sh[ChTor], 1'b1);
    return c;
  endfunction

  function automatic cmd_t same_cmd(logic signed [31:0] v);
    cmd_t c;
    c.position = v;
    c.velocity = v;
    c.stiffness_gain = v;
    c.damping_gain = v;
    c.torque_ff = v;
    return c;
  endfunction

  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return LimW'($urandom_range(1, 16));
      1: return {LimW{1'b1}};
      2: return LimW'($urandom_range(1, 1 << 20));
      default: return LimW'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      // With hold_mid set, the sender holds back once, mid-phase, until the pipeline has emptied.
      if (hold_mid && i == n / 2) begin
        stop_cmd();
        while (pending != 0) @(posedge clk_i);
      end
      send_cmd(pick_cmd());
    end
    stop_cmd();
  endtask

  initial begin
    lim_sh[ChPos] = LimW'(819200);
    lim_sh[ChVel] = LimW'(2949120);
    lim_sh[ChStf] = LimW'(32768000);
    lim_sh[ChDmp] = LimW'(327680);
    lim_sh[ChTor] = LimW'(1179648);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, the extremes of the field, the bounds at reset limits,
    // just outside and just inside them, and negative gains.
    send_cmd(same_cmd(32'sd0));
    send_cmd(same_cmd(32'sh7FFFFFFF));
    send_cmd(same_cmd(32'sh80000000));
    send_cmd(same_cmd(-32'sd1));
    send_cmd(same_cmd(32'sd1));
    for (int ch = 0; ch < 2; ch++) begin
      cmd_t c;
      c.position = ch ? -32'sd819200 : 32'sd819200;
      c.velocity = ch ? -32'sd2949120 : 32'sd2949120;
      c.stiffness_gain = ch ? -32'sd32768000 : 32'sd32768000;
      c.damping_gain = ch ? -32'sd327680 : 32'sd327680;
      c.torque_ff = ch ? -32'sd1179648 : 32'sd1179648;
      send_cmd(c);
      c.position = ch ? -32'sd819201 : 32'sd819201;
      c.velocity = ch ? -32'sd2949121 : 32'sd2949121;
      c.stiffness_gain = ch ? -32'sd1 : 32'sd32768001;
      c.damping_gain = ch ? -32'sd327681 : 32'sd327681;
      c.torque_ff = ch ? -32'sd1179649 : 32'sd1179649;
      send_cmd(c);
      c.position = ch ? -32'sd819199 : 32'sd819199;
      c.velocity = ch ? -32'sd2949119 : 32'sd2949119;
      c.stiffness_gain = ch ? 32'sd1 : 32'sd32767999;
      c.damping_gain = ch ? 32'sd1 : 32'sd327679;
      c.torque_ff = ch ? -32'sd1179647 : 32'sd1179647;
      send_cmd(c);
    end
    stop_cmd();

    // Zero limits give zero codes everywhere; id bits above the width and
    // writes to indexes past the list must be ignored.
    set_limits(LimW'(32'h7FFFF800), '0, '0, '0, '0, '0);
    write_reg(3'd6, {LimW{1'b1}});
    write_reg(3'd7, '0);
    send_cmd(same_cmd(32'sh7FFFFFFF));
    send_cmd(same_cmd(32'sh80000000));
    send_cmd(same_cmd(32'sd12345));
    stop_cmd();

    // Widest ranges, with full-scale and near-bound values.
    set_limits(LimW'(2047), {LimW{1'b1}}, {LimW{1'b1}}, {LimW{1'b1}},
               {LimW{1'b1}}, {LimW{1'b1}});
    send_cmd(same_cmd(32'sh7FFFFFFF));
    send_cmd(same_cmd(32'sh80000000));
    send_cmd(same_cmd(32'sh80000001));
    send_cmd(same_cmd(32'sh7FFFFFFE));
    stop_cmd();
    random_phase(120, 1'b0);

    // Narrowest ranges.
    set_limits(LimW'(0), LimW'(1), LimW'(1), LimW'(1), LimW'(1), LimW'(1));
    random_phase(120, 1'b0);

    // Reset values again, with a long stretch of no idling on either side.
    set_limits(LimW'(1), LimW'(819200), LimW'(2949120), LimW'(32768000),
               LimW'(327680), LimW'(1179648));
    quiet = 1'b1;
    random_phase(150, 1'b0);
    quiet = 1'b0;

    // Random settings, one phase each.
    for (int ph = 0; ph < 4; ph++) begin
      set_limits(LimW'($urandom), pick_limit(), pick_limit(), pick_limit(),
                 pick_limit(), pick_limit());
      random_phase(110, ph == 0);
    end

    wait_drained();
    $display("Sent %0d commands over eight limit settings, from zero and one to full",
             sent);
    $display("scale, with random stalls, a no-stall stretch and a full drain mid-phase.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
